[sv/ordered_value_list_table_top_defines.svh]
// Assertion macros used by the ordered value list table checker.
`ifndef ORDERED_VALUE_LIST_TABLE_TOP_DEFINES_SVH
`define ORDERED_VALUE_LIST_TABLE_TOP_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define OVLT_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ordered value list table check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define OVLT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ordered value list table check failed");

`endif

[sv/ovlt_pkg.sv]
// Package with the types, codes and defaults of the ordered value list table.
`default_nettype none

package ovlt_pkg;

    localparam int unsigned CAPACITY_DEF = 64;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_SEARCH = 2'd2;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_MISSING = 2'd1;
    localparam logic [1:0] STATUS_FULL    = 2'd2;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] value;
    } in_t;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] position;
        logic [6:0] entry_count;
    } out_t;

    typedef struct packed {
        logic busy;
        logic res_valid;
    } ctl_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT_UP,
        ST_SHIFT_DN,
        ST_BIN_RD,
        ST_BIN_CMP,
        ST_MV_RD,
        ST_MV_WR,
        ST_PUT,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

[sv/ovlt_core.sv]
// Sequencer and entry memory of the ordered value list table.
`default_nettype none

module ovlt_core #(
    parameter int unsigned CAPACITY = 64
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         sorted_mode,
    input  wire logic         start,
    input  ovlt_pkg::in_t     req,
    input  wire logic         res_take,
    output ovlt_pkg::ctl_t    ctl,
    output ovlt_pkg::out_t    res
);
    import ovlt_pkg::*;

    localparam int unsigned IDX_W = $clog2(CAPACITY);
    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

    logic [31:0] entries_reg [CAPACITY];
    logic [31:0] rdata_reg;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic pend_reg, pend_next;
    logic [1:0] cmd_reg, cmd_next;
    logic [31:0] value_reg, value_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] at_reg, at_next;
    logic [CNT_W-1:0] lo_reg, lo_next;
    logic [CNT_W-1:0] hi_reg, hi_next;
    logic [IDX_W-1:0] mid_reg, mid_next;
    logic [IDX_W-1:0] pend_addr_reg, pend_addr_next;
    logic [1:0] res_status_reg, res_status_next;
    logic [CNT_W-1:0] res_pos_reg, res_pos_next;

    logic rd_en, wr_en;
    logic [IDX_W-1:0] rd_addr, wr_addr;
    logic [31:0] wr_data;

    logic [CNT_W-1:0] idx_inc, idx_dec, cnt_dec;
    logic [CNT_W:0] mid_sum;
    logic [IDX_W-1:0] mid_calc;
    logic scan_more, up_more, dn_more, bin_open;
    logic hit_eq, hit_ge, hit_gt, scan_hit;

    assign idx_inc   = idx_reg + CNT_W'(1);
    assign idx_dec   = idx_reg - CNT_W'(1);
    assign cnt_dec   = count_reg - CNT_W'(1);
    assign mid_sum   = {1'b0, lo_reg} + {1'b0, hi_reg} - (CNT_W + 1)'(1);
    assign mid_calc  = mid_sum[IDX_W:1];
    assign scan_more = idx_reg < count_reg;
    assign up_more   = idx_reg > at_reg;
    assign dn_more   = idx_inc < count_reg;
    assign bin_open  = lo_reg < hi_reg;
    assign hit_eq    = rdata_reg == value_reg;
    assign hit_ge    = $signed(value_reg) <= $signed(rdata_reg);
    assign hit_gt    = $signed(rdata_reg) > $signed(value_reg);
    assign scan_hit  = pend_reg && ((cmd_reg == CMD_INSERT) ? hit_ge : hit_eq);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entries_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= entries_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        value_reg      <= value_next;
        idx_reg        <= idx_next;
        at_reg         <= at_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        pend_addr_reg  <= pend_addr_next;
        res_status_reg <= res_status_next;
        res_pos_reg    <= res_pos_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        pend_next       = pend_reg;
        cmd_next        = cmd_reg;
        value_next      = value_reg;
        idx_next        = idx_reg;
        at_next         = at_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        pend_addr_next  = pend_addr_reg;
        res_status_next = res_status_reg;
        res_pos_next    = res_pos_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next        = req.cmd;
                    value_next      = $unsigned(req.value);
                    idx_next        = '0;
                    pend_next       = 1'b0;
                    lo_next         = '0;
                    hi_next         = count_reg;
                    at_next         = count_reg;
                    res_status_next = STATUS_MISSING;
                    res_pos_next    = '0;
                    unique case (req.cmd)
                        CMD_INSERT:
                        begin
                            if (count_reg == CNT_W'(CAPACITY))
                            begin
                                res_status_next = STATUS_FULL;
                                state_next      = ST_DONE;
                            end
                            else if (!sorted_mode || count_reg == '0)
                            begin
                                state_next = ST_PUT;
                            end
                            else
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        CMD_REMOVE, CMD_SEARCH:
                        begin
                            state_next = sorted_mode ? ST_BIN_RD : ST_SCAN;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                idx_next       = scan_more ? idx_inc : idx_reg;
                pend_next      = scan_more;
                pend_addr_next = idx_reg[IDX_W-1:0];
                if (scan_hit)
                begin
                    at_next = CNT_W'(pend_addr_reg);
                    if (cmd_reg == CMD_INSERT)
                    begin
                        idx_next   = count_reg;
                        pend_next  = 1'b0;
                        state_next = ST_SHIFT_UP;
                    end
                    else if (cmd_reg == CMD_SEARCH)
                    begin
                        res_status_next = STATUS_OK;
                        res_pos_next    = CNT_W'(pend_addr_reg);
                        state_next      = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_MV_RD;
                    end
                end
                else if (!pend_reg && !scan_more)
                begin
                    state_next = (cmd_reg == CMD_INSERT) ? ST_PUT : ST_DONE;
                end
            end
            ST_SHIFT_UP:
            begin
                idx_next       = up_more ? idx_dec : idx_reg;
                pend_next      = up_more;
                pend_addr_next = idx_reg[IDX_W-1:0];
                if (!pend_reg && !up_more)
                begin
                    state_next = ST_PUT;
                end
            end
            ST_SHIFT_DN:
            begin
                idx_next       = dn_more ? idx_inc : idx_reg;
                pend_next      = dn_more;
                pend_addr_next = idx_reg[IDX_W-1:0];
                if (!pend_reg && !dn_more)
                begin
                    count_next      = cnt_dec;
                    res_status_next = STATUS_OK;
                    res_pos_next    = at_reg;
                    state_next      = ST_DONE;
                end
            end
            ST_BIN_RD:
            begin
                if (bin_open)
                begin
                    mid_next   = mid_calc;
                    state_next = ST_BIN_CMP;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_BIN_CMP:
            begin
                if (hit_eq)
                begin
                    at_next = CNT_W'(mid_reg);
                    if (cmd_reg == CMD_SEARCH)
                    begin
                        res_status_next = STATUS_OK;
                        res_pos_next    = CNT_W'(mid_reg);
                        state_next      = ST_DONE;
                    end
                    else
                    begin
                        idx_next   = CNT_W'(mid_reg);
                        pend_next  = 1'b0;
                        state_next = ST_SHIFT_DN;
                    end
                end
                else
                begin
                    if (hit_gt)
                    begin
                        hi_next = CNT_W'(mid_reg);
                    end
                    else
                    begin
                        lo_next = CNT_W'(mid_reg) + CNT_W'(1);
                    end
                    state_next = ST_BIN_RD;
                end
            end
            ST_MV_RD:
            begin
                state_next = ST_MV_WR;
            end
            ST_MV_WR:
            begin
                count_next      = cnt_dec;
                res_status_next = STATUS_OK;
                res_pos_next    = at_reg;
                state_next      = ST_DONE;
            end
            ST_PUT:
            begin
                count_next      = count_reg + CNT_W'(1);
                res_status_next = STATUS_OK;
                res_pos_next    = at_reg;
                state_next      = ST_DONE;
            end
            ST_DONE:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = idx_reg[IDX_W-1:0];
        wr_en   = 1'b0;
        wr_addr = pend_addr_reg;
        wr_data = rdata_reg;
        unique case (state_reg)
            ST_SCAN:
            begin
                rd_en = scan_more;
            end
            ST_SHIFT_UP:
            begin
                rd_en   = up_more;
                rd_addr = idx_dec[IDX_W-1:0];
                wr_en   = pend_reg;
            end
            ST_SHIFT_DN:
            begin
                rd_en   = dn_more;
                rd_addr = idx_inc[IDX_W-1:0];
                wr_en   = pend_reg;
            end
            ST_BIN_RD:
            begin
                rd_en   = bin_open;
                rd_addr = mid_calc;
            end
            ST_MV_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = cnt_dec[IDX_W-1:0];
            end
            ST_MV_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = at_reg[IDX_W-1:0];
            end
            ST_PUT:
            begin
                wr_en   = 1'b1;
                wr_addr = at_reg[IDX_W-1:0];
                wr_data = value_reg;
            end
            ST_IDLE, ST_BIN_CMP, ST_DONE:
            begin
                rd_en = 1'b0;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    assign ctl.busy         = state_reg != ST_IDLE;
    assign ctl.res_valid    = state_reg == ST_DONE;
    assign res.status       = res_status_reg;
    assign res.position     = 6'(res_pos_reg);
    assign res.entry_count  = 7'(count_reg);

endmodule

`default_nettype wire

[sv/ordered_value_list_table_top.sv]
// Ordered value list table: mode register, request sequencer and result register.
// One request is in work at a time. Scans and shifts walk the single entry memory one entry
// per cycle; a binary search probe reads the middle entry, then compares it. A new request is
// taken while a result waits in the result register, not while the sequencer still holds it.
// Reset clears the entry count, the mode register and all valid flags; entries are not cleared.
`default_nettype none

module ordered_value_list_table_top #(
    parameter int unsigned CAPACITY = ovlt_pkg::CAPACITY_DEF
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cfg_wr_en,
    input  wire logic      cfg_wr_data,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  ovlt_pkg::in_t  in_data,
    output logic           out_valid,
    input  wire logic      out_stall,
    output ovlt_pkg::out_t out_data
);
    import ovlt_pkg::*;

    logic sorted_mode_reg;
    logic out_valid_reg, out_valid_next;
    out_t out_data_reg, out_data_next;
    ctl_t core_ctl;
    out_t core_res;
    logic start, res_take;

    assign in_stall = core_ctl.busy;
    assign start    = in_valid && !core_ctl.busy;
    assign res_take = core_ctl.res_valid && (!out_valid_reg || !out_stall);

    ovlt_core #(
        .CAPACITY (CAPACITY)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .sorted_mode (sorted_mode_reg),
        .start       (start),
        .req         (in_data),
        .res_take    (res_take),
        .ctl         (core_ctl),
        .res         (core_res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
            out_data_next  = core_res;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sorted_mode_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                sorted_mode_reg <= cfg_wr_data;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

[sv/ovlt_checker.sv]
// Port-level checker of the ordered value list table and its bind.
`default_nettype none

`include "ordered_value_list_table_top_defines.svh"

module ovlt_checker (
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      in_valid,
    input wire logic      in_stall,
    input wire logic      out_valid,
    input wire logic      out_stall,
    input ovlt_pkg::out_t out_data
);
    import ovlt_pkg::*;

    // A stalled result holds its value until it is taken.
    `OVLT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
    // An accepted request keeps the block busy in the following cycle.
    `OVLT_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
    `OVLT_ASSERT_SAME(a_status_code, out_valid, out_data.status != 2'd3)
    // Any status other than OK reports position zero.
    `OVLT_ASSERT_SAME(a_pos_zero, out_valid && out_data.status != STATUS_OK,
        out_data.position == 6'd0)

endmodule

bind ordered_value_list_table_top ovlt_checker u_ovlt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

`default_nettype wire

[bench/tb_ordered_value_list_table_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the ordered value list table in unsorted and sorted modes.
module tb_ordered_value_list_table_top;
    import ovlt_pkg::*;

    localparam int unsigned CAPACITY = CAPACITY_DEF;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int unsigned RANDOM_ITEMS = 800;
    localparam int unsigned IDLE_LIMIT = 4000;
    localparam int unsigned SETTLE_CYCLES = 150;

    class value_table_tracker;
        bit sorted;
        logic signed [31:0] entries [CAPACITY];
        int unsigned fill;
        out_t awaited_results [$];
        int mismatches;

        function new();
            sorted = 1'b0;
            fill = 0;
            mismatches = 0;
        endfunction

        function bit locate(logic signed [31:0] v, output int unsigned at);
            int unsigned lo;
            int unsigned hi;
            int unsigned mid;
            at = 0;
            if (sorted)
            begin
                lo = 0;
                hi = fill;
                while (lo < hi)
                begin
                    mid = (lo + hi - 1) / 2;
                    if (entries[mid] == v)
                    begin
                        at = mid;
                        return 1'b1;
                    end
                    if (entries[mid] > v)
                        hi = mid;
                    else
                        lo = mid + 1;
                end
                return 1'b0;
            end
            for (int unsigned i = 0; i < fill; i++)
            begin
                if (entries[i] == v)
                begin
                    at = i;
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function out_t table_outcome(in_t req);
            out_t res;
            logic signed [31:0] v;
            int unsigned at;
            bit placed;
            v = $signed(req.value);
            res.status = STATUS_MISSING;
            res.position = '0;
            case (req.cmd)
                CMD_INSERT:
                begin
                    if (fill >= CAPACITY)
                    begin
                        res.status = STATUS_FULL;
                    end
                    else
                    begin
                        at = fill;
                        if (sorted)
                        begin
                            placed = 1'b0;
                            for (int unsigned i = 0; i < fill; i++)
                            begin
                                if (!placed && v <= entries[i])
                                begin
                                    at = i;
                                    placed = 1'b1;
                                end
                            end
                            for (int unsigned i = fill; i > at; i--)
                                entries[i] = entries[i - 1];
                        end
                        entries[at] = v;
                        fill++;
                        res.status = STATUS_OK;
                        res.position = 6'(at);
                    end
                end
                CMD_REMOVE:
                begin
                    if (locate(v, at))
                    begin
                        if (sorted)
                        begin
                            for (int unsigned i = at; i + 1 < fill; i++)
                                entries[i] = entries[i + 1];
                        end
                        else
                        begin
                            entries[at] = entries[fill - 1];
                        end
                        fill--;
                        res.status = STATUS_OK;
                        res.position = 6'(at);
                    end
                end
                CMD_SEARCH:
                begin
                    if (locate(v, at))
                    begin
                        res.status = STATUS_OK;
                        res.position = 6'(at);
                    end
                end
                default:
                begin
                end
            endcase
            res.entry_count = 7'(fill);
            return res;
        endfunction

        function void note_request(in_t req);
            awaited_results.push_back(table_outcome(req));
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            mismatches++;
        endtask

        task check_result(out_t got);
            out_t exp;
            if (awaited_results.size() == 0)
            begin
                report($sformatf("unexpected result status %0d position %0d count %0d",
                                 got.status, got.position, got.entry_count));
                return;
            end
            exp = awaited_results.pop_front();
            if (got.status !== exp.status)
                report($sformatf("status got %0d expected %0d", got.status, exp.status));
            if (got.position !== exp.position)
                report($sformatf("position got %0d expected %0d", got.position, exp.position));
            if (got.entry_count !== exp.entry_count)
                report($sformatf("entry_count got %0d expected %0d",
                                 got.entry_count, exp.entry_count));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic cfg_wr_data = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    in_t  in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_t out_data;

    value_table_tracker tracker;
    bit calm = 1'b0;
    int unsigned idle_cycles = 0;

    ordered_value_list_table_top #(
        .CAPACITY(CAPACITY)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            tracker.note_request(in_data);
        if (rst_n && out_valid && !out_stall)
            tracker.check_result(out_data);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        int unsigned hold;
        forever
        begin
            @(negedge clk);
            hold = calm ? 0 : $urandom_range(0, 8);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!(rst_n && out_valid));
        end
    end

    task automatic send_request(in_t req);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= req;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic set_mode(bit sorted_mode);
        in_valid <= 1'b0;
        while (tracker.awaited_results.size() != 0) @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= sorted_mode;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        tracker.sorted = sorted_mode;
    endtask

    function automatic logic signed [31:0] any_value();
        case ($urandom_range(0, 9))
            0, 1, 2: return $signed($urandom_range(0, 8)) - 4;
            3:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7fff_ffff;
                    2: return 32'sd0;
                    default: return -32'sd1;
                endcase
            end
            default: return $signed($urandom);
        endcase
    endfunction

    function automatic logic signed [31:0] probe_value();
        if (tracker.fill > 0 && $urandom_range(0, 9) < 7)
            return tracker.entries[$urandom_range(0, tracker.fill - 1)];
        return any_value();
    endfunction

    function automatic in_t make_request(int flavor);
        in_t req;
        int unsigned roll;
        int unsigned insert_cut;
        int unsigned remove_cut;
        roll = $urandom_range(0, 99);
        case (flavor)
            0:
            begin
                insert_cut = 95;
                remove_cut = 97;
            end
            1:
            begin
                insert_cut = 30;
                remove_cut = 80;
            end
            default:
            begin
                insert_cut = 45;
                remove_cut = 70;
            end
        endcase
        if (roll < 3)
        begin
            req.cmd = CMD_UNUSED;
            req.value = $signed($urandom);
        end
        else if (roll < insert_cut)
        begin
            req.cmd = CMD_INSERT;
            req.value = any_value();
        end
        else if (roll < remove_cut)
        begin
            req.cmd = CMD_REMOVE;
            req.value = probe_value();
        end
        else
        begin
            req.cmd = CMD_SEARCH;
            req.value = probe_value();
        end
        return req;
    endfunction

    initial
    begin
        int unsigned issued;
        int unsigned phase;
        int unsigned count;
        int flavor;
        bit sorted_mode;
        tracker = new();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        set_mode(1'b0);
        send_request(in_t'{CMD_SEARCH, 32'sd5});
        send_request(in_t'{CMD_REMOVE, 32'sd5});
        send_request(in_t'{CMD_UNUSED, 32'sd0});
        send_request(in_t'{CMD_INSERT, 32'sh8000_0000});
        send_request(in_t'{CMD_INSERT, 32'sh7fff_ffff});
        send_request(in_t'{CMD_INSERT, 32'sd0});
        send_request(in_t'{CMD_INSERT, -32'sd1});
        send_request(in_t'{CMD_INSERT, 32'sd0});
        send_request(in_t'{CMD_SEARCH, 32'sd0});
        send_request(in_t'{CMD_REMOVE, 32'sh8000_0000});
        send_request(in_t'{CMD_SEARCH, 32'sd7});
        send_request(in_t'{CMD_UNUSED, -32'sd1});

        // The table still holds unordered entries when sorted mode is switched on.
        set_mode(1'b1);
        send_request(in_t'{CMD_SEARCH, -32'sd1});
        send_request(in_t'{CMD_INSERT, 32'sh8000_0000});
        send_request(in_t'{CMD_INSERT, 32'sh7fff_ffff});
        send_request(in_t'{CMD_INSERT, 32'sd3});
        send_request(in_t'{CMD_SEARCH, 32'sd3});
        send_request(in_t'{CMD_REMOVE, 32'sd0});
        send_request(in_t'{CMD_REMOVE, 32'sh1234_5678});
        send_request(in_t'{CMD_UNUSED, 32'sh5555_aaaa});

        issued = 0;
        phase = 0;
        while (issued < RANDOM_ITEMS)
        begin
            flavor = (phase == 0) ? 0 : $urandom_range(0, 2);
            sorted_mode = (phase == 0) ? 1'b1 : 1'($urandom_range(0, 1));
            calm = (phase != 0) && ($urandom_range(0, 3) == 0);
            if (tracker.fill > 0 && $urandom_range(0, 3) != 0)
            begin
                set_mode(1'b0);
                while (tracker.fill > 0)
                begin
                    send_request(in_t'{CMD_REMOVE, tracker.entries[tracker.fill - 1]});
                    issued++;
                end
            end
            set_mode(sorted_mode);
            count = (flavor == 0) ? 75 : $urandom_range(40, 120);
            repeat (count)
            begin
                send_request(make_request(flavor));
                issued++;
            end
            phase++;
        end

        in_valid <= 1'b0;
        while (tracker.awaited_results.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (tracker.mismatches == 0 && tracker.awaited_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

[ordered_value_list_table_top.f]
+incdir+sv
sv/ovlt_pkg.sv
sv/ovlt_core.sv
sv/ordered_value_list_table_top.sv
sv/ovlt_checker.sv
bench/tb_ordered_value_list_table_top.sv
